// ----- hdl/serial_link_shift_port_assert.svh -----
// assertion macros for the serial link shift port checker
// expects signals named clk and arst_n in the scope of use
`ifndef SERIAL_LINK_SHIFT_PORT_ASSERT_SVH
`define SERIAL_LINK_SHIFT_PORT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLSP_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLSP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/slsp_pkg.sv -----
// shared constants, codes and types of the serial link shift port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slsp_pkg;

	// payload widths
	localparam int OP_W    = 2;
	localparam int ADDR_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int CYC_W   = 8;
	localparam int PBITS_W = 2;
	localparam int CNT_W   = 3;

	// operation codes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
	localparam logic [OP_W-1:0] OP_EXT   = 2'd3;

	// register addresses
	localparam logic [ADDR_W-1:0] ADDR_DATA = 16'hFF01;
	localparam logic [ADDR_W-1:0] ADDR_CTRL = 16'hFF02;

	// control register bit positions
	localparam int CTRL_START = 7;
	localparam int CTRL_FAST  = 1;
	localparam int CTRL_INT   = 0;

	// value read back for anything but a register read
	localparam logic [BYTE_W-1:0] READ_IDLE = 8'hFF;

	// bit periods in cpu cycles, both powers of two
	localparam int NORMAL_BIT_PERIOD = 512;
	localparam int FAST_BIT_PERIOD   = 256;
	localparam int MAX_PERIOD  = (NORMAL_BIT_PERIOD > FAST_BIT_PERIOD) ?
		NORMAL_BIT_PERIOD : FAST_BIT_PERIOD;
	localparam int NORMAL_SHIFT = $clog2(NORMAL_BIT_PERIOD);
	localparam int FAST_SHIFT   = $clog2(FAST_BIT_PERIOD);
	localparam int ACC_W = $clog2(MAX_PERIOD);
	localparam int SUM_W = $clog2(MAX_PERIOD + (1 << CYC_W));

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARTNER    = 1'd1;

	// job queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic color_mode;
		logic partner_present;
	} slsp_cfg_t;

	// one executed item: up to two result beats
	typedef struct packed {
		logic [BYTE_W-1:0] rd;
		logic              two;
		logic              sh0;
		logic              ob0;
		logic              done0;
		logic              ob1;
		logic              done1;
	} slsp_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} slsp_qstat_t;

endpackage

`default_nettype wire

// ----- hdl/slsp_req_if.sv -----
// request channel of the serial link shift port
// depends on slsp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface slsp_req_if;
	logic                             valid;
	logic                             ready;
	logic [slsp_pkg::OP_W-1:0]        operation;
	logic [slsp_pkg::ADDR_W-1:0]      address;
	logic [slsp_pkg::BYTE_W-1:0]      write_data;
	logic [slsp_pkg::CYC_W-1:0]       elapsed_cycles;
	logic [slsp_pkg::PBITS_W-1:0]     partner_bits;

	modport source (
		output valid, operation, address, write_data, elapsed_cycles, partner_bits,
		input  ready
	);
	modport sink (
		input  valid, operation, address, write_data, elapsed_cycles, partner_bits,
		output ready
	);
endinterface

`default_nettype wire

// ----- hdl/slsp_rsp_if.sv -----
// response channel of the serial link shift port
// depends on slsp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface slsp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [slsp_pkg::BYTE_W-1:0] read_data;
	logic                        shift_happened;
	logic                        out_bit;
	logic                        transfer_done;
	logic                        last;

	modport source (
		output valid, read_data, shift_happened, out_bit, transfer_done, last,
		input  ready
	);
	modport sink (
		input  valid, read_data, shift_happened, out_bit, transfer_done, last,
		output ready
	);
endinterface

`default_nettype wire

// ----- hdl/serial_link_shift_port.sv -----
// serial link shift port (8-bit data register at 0xff01, control at 0xff02).
// every request beat is an access (write, read), a cpu cycle tick or an
// external clock edge; each gives one response beat, except a tick that
// spends two bit periods during a transfer without its first shift ending
// it, which gives two (last marks the final one). the port takes one request
// beat per cycle; request ready falls only when the four-entry job queue
// between front end and result sequencer is full, which happens when the
// response side stalls or when two-beat ticks come in a row. the job of a
// taken request is written into the queue and then moves into the output
// register, which offers the result; a two-beat tick gives two beats there.
// configuration (color_mode, partner_present) is written through cfg_we /
// cfg_index / cfg_wdata; the user must write it only while the port is
// idle, which the block itself does not enforce.
// depends on slsp_pkg, slsp_req_if, slsp_rsp_if, slsp_front, slsp_queue, slsp_back
`timescale 1ns / 1ps
`default_nettype none

module serial_link_shift_port (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [slsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [slsp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	slsp_req_if.sink                               req,
	slsp_rsp_if.source                             rsp
);

	slsp_pkg::slsp_cfg_t   cfg_q;
	slsp_pkg::slsp_qstat_t qstat;
	slsp_pkg::slsp_job_t   push_job, head;
	logic                  push, pop;

	// configuration registers, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				slsp_pkg::CFG_COLOR_MODE: cfg_q.color_mode      <= cfg_wdata[0];
				slsp_pkg::CFG_PARTNER:    cfg_q.partner_present <= cfg_wdata[0];
				default:                  cfg_q <= cfg_q;
			endcase
		end
	end

	// front end: decode, state update, job build
	slsp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.qstat  (qstat),
		.push   (push),
		.job    (push_job)
	);

	// job queue decouples request acceptance from response stalls
	slsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.qstat    (qstat),
		.head     (head)
	);

	// back end: one or two response beats per job
	slsp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ----- hdl/slsp_front.sv -----
// front end: accepts request beats, decodes them, updates port state, queues a job
// depends on slsp_pkg and slsp_req_if
`timescale 1ns / 1ps
`default_nettype none

module slsp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire slsp_pkg::slsp_cfg_t   cfg,
	slsp_req_if.sink                req,
	input  wire slsp_pkg::slsp_qstat_t qstat,
	output logic                    push,
	output slsp_pkg::slsp_job_t     job
);

	logic [slsp_pkg::BYTE_W-1:0] shift_data_q, shift_data_n;
	logic                        active_q, active_n;
	logic                        fast_q, fast_n;
	logic                        intclk_q, intclk_n;
	logic [slsp_pkg::CNT_W-1:0]  bit_count_q, bit_count_n;
	logic [slsp_pkg::ACC_W-1:0]  accum_q, accum_n;

	logic                        is_data, is_ctrl;
	logic [slsp_pkg::SUM_W-1:0]  sum, periods;
	logic [slsp_pkg::ACC_W-1:0]  accum_rem;
	logic                        tin0, tin1, tick_sh0, tick_sh1;
	logic [slsp_pkg::BYTE_W-1:0] sd_a, sd_b;

	assign req.ready = !qstat.full;
	assign push      = req.valid && !qstat.full;

	assign is_data = (req.address == slsp_pkg::ADDR_DATA);
	assign is_ctrl = (req.address == slsp_pkg::ADDR_CTRL);

	// bit period accounting, periods are powers of two
	assign sum = slsp_pkg::SUM_W'(accum_q) + slsp_pkg::SUM_W'(req.elapsed_cycles);
	always_comb begin
		if (fast_q) begin
			periods   = sum >> slsp_pkg::FAST_SHIFT;
			accum_rem = slsp_pkg::ACC_W'(sum & slsp_pkg::SUM_W'(slsp_pkg::FAST_BIT_PERIOD - 1));
		end else begin
			periods   = sum >> slsp_pkg::NORMAL_SHIFT;
			accum_rem = slsp_pkg::ACC_W'(sum & slsp_pkg::SUM_W'(slsp_pkg::NORMAL_BIT_PERIOD - 1));
		end
	end

	// no partner: internal clock shifts take in ones
	assign tin0 = cfg.partner_present ? req.partner_bits[0] : 1'b1;
	assign tin1 = cfg.partner_present ? req.partner_bits[1] : 1'b1;

	assign tick_sh0 = intclk_q && active_q && (periods != '0);
	// second shift only if the first did not end the transfer
	assign tick_sh1 = tick_sh0 && (periods > slsp_pkg::SUM_W'(1)) &&
		(bit_count_q != slsp_pkg::CNT_W'(7));

	assign sd_a = {shift_data_q[slsp_pkg::BYTE_W-2:0], tin0};
	assign sd_b = {sd_a[slsp_pkg::BYTE_W-2:0], tin1};

	always_comb begin
		job          = '0;
		job.rd       = slsp_pkg::READ_IDLE;
		shift_data_n = shift_data_q;
		active_n     = active_q;
		fast_n       = fast_q;
		intclk_n     = intclk_q;
		bit_count_n  = bit_count_q;
		accum_n      = accum_q;
		case (req.operation)
			slsp_pkg::OP_WRITE: begin
				if (is_data) begin
					shift_data_n = req.write_data;
				end else if (is_ctrl) begin
					active_n = req.write_data[slsp_pkg::CTRL_START];
					fast_n   = cfg.color_mode & req.write_data[slsp_pkg::CTRL_FAST];
					intclk_n = req.write_data[slsp_pkg::CTRL_INT];
				end
			end
			slsp_pkg::OP_READ: begin
				if (is_data) begin
					job.rd = shift_data_q;
				end else if (is_ctrl) begin
					job.rd = '0;
					job.rd[slsp_pkg::CTRL_START] = active_q;
					job.rd[slsp_pkg::CTRL_FAST]  = fast_q;
					job.rd[slsp_pkg::CTRL_INT]   = intclk_q;
				end
			end
			slsp_pkg::OP_EXT: begin
				if (active_q) begin
					job.sh0      = 1'b1;
					job.ob0      = shift_data_q[slsp_pkg::BYTE_W-1];
					job.done0    = (bit_count_q == slsp_pkg::CNT_W'(7));
					shift_data_n = {shift_data_q[slsp_pkg::BYTE_W-2:0], req.partner_bits[0]};
					bit_count_n  = bit_count_q + slsp_pkg::CNT_W'(1);
					active_n     = !job.done0;
				end
			end
			slsp_pkg::OP_TICK: begin
				accum_n = accum_rem;
				if (tick_sh1) begin
					job.two      = 1'b1;
					job.sh0      = 1'b1;
					job.ob0      = shift_data_q[slsp_pkg::BYTE_W-1];
					job.ob1      = sd_a[slsp_pkg::BYTE_W-1];
					job.done1    = (bit_count_q == slsp_pkg::CNT_W'(6));
					shift_data_n = sd_b;
					bit_count_n  = bit_count_q + slsp_pkg::CNT_W'(2);
					active_n     = !job.done1;
				end else if (tick_sh0) begin
					job.sh0      = 1'b1;
					job.ob0      = shift_data_q[slsp_pkg::BYTE_W-1];
					job.done0    = (bit_count_q == slsp_pkg::CNT_W'(7));
					shift_data_n = sd_a;
					bit_count_n  = bit_count_q + slsp_pkg::CNT_W'(1);
					active_n     = !job.done0;
				end
			end
			default: begin
				job.rd = slsp_pkg::READ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_data_q <= '0;
			active_q     <= 1'b0;
			fast_q       <= 1'b0;
			intclk_q     <= 1'b0;
			bit_count_q  <= '0;
			accum_q      <= '0;
		end else if (push) begin
			shift_data_q <= shift_data_n;
			active_q     <= active_n;
			fast_q       <= fast_n;
			intclk_q     <= intclk_n;
			bit_count_q  <= bit_count_n;
			accum_q      <= accum_n;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/slsp_queue.sv -----
// small job fifo between the front end and the result sequencer
// depends on slsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module slsp_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire slsp_pkg::slsp_job_t  push_job,
	input  wire logic                 pop,
	output slsp_pkg::slsp_qstat_t     qstat,
	output slsp_pkg::slsp_job_t       head
);

	slsp_pkg::slsp_job_t           slot_q [slsp_pkg::QDEPTH];
	logic [slsp_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [slsp_pkg::QPTR_W:0]     count_q;

	assign qstat.full  = (count_q == (slsp_pkg::QPTR_W + 1)'(slsp_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + slsp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + slsp_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (slsp_pkg::QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (slsp_pkg::QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/slsp_back.sv -----
// back end: turns queued jobs into one or two response beats in an output register
// depends on slsp_pkg and slsp_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module slsp_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire slsp_pkg::slsp_qstat_t qstat,
	input  wire slsp_pkg::slsp_job_t   head,
	output logic                       pop,
	slsp_rsp_if.source                 rsp
);

	logic                        valid_q;
	logic                        second_q;
	logic [slsp_pkg::BYTE_W-1:0] rd_q;
	logic                        sh_q, ob_q, done_q, last_q;
	logic                        load, first_of_two;

	assign load         = !valid_q || rsp.ready;
	assign first_of_two = head.two && !second_q;
	assign pop          = load && !qstat.empty && !first_of_two;

	assign rsp.valid          = valid_q;
	assign rsp.read_data      = rd_q;
	assign rsp.shift_happened = sh_q;
	assign rsp.out_bit        = ob_q;
	assign rsp.transfer_done  = done_q;
	assign rsp.last           = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !qstat.empty;
			if (!qstat.empty) begin
				second_q <= first_of_two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !qstat.empty) begin
			if (first_of_two) begin
				rd_q   <= slsp_pkg::READ_IDLE;
				sh_q   <= 1'b1;
				ob_q   <= head.ob0;
				done_q <= head.done0;
				last_q <= 1'b0;
			end else if (second_q) begin
				rd_q   <= slsp_pkg::READ_IDLE;
				sh_q   <= 1'b1;
				ob_q   <= head.ob1;
				done_q <= head.done1;
				last_q <= 1'b1;
			end else begin
				rd_q   <= head.rd;
				sh_q   <= head.sh0;
				ob_q   <= head.ob0;
				done_q <= head.done0;
				last_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/slsp_checker.sv -----
// port-level checks on the response side of the serial link shift port
// depends on serial_link_shift_port_assert.svh and slsp_pkg; bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "serial_link_shift_port_assert.svh"

module slsp_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rsp_valid,
	input  wire logic                        rsp_ready,
	input  wire logic [slsp_pkg::BYTE_W-1:0] read_data,
	input  wire logic                        shift_happened,
	input  wire logic                        out_bit,
	input  wire logic                        transfer_done,
	input  wire logic                        last
);

	// a stalled beat stays offered
	`SLSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response beat dropped")

	// a beat with no shift is a single clean beat
	`SLSP_ASSERT_IMPL(a_noshift_clean, rsp_valid && !shift_happened, !out_bit && !transfer_done && last, "no-shift beat malformed")

	// the eighth shift always ends its item
	`SLSP_ASSERT_IMPL(a_done_last, rsp_valid && transfer_done, last && read_data == slsp_pkg::READ_IDLE, "transfer done beat malformed")

	// the first beat of a two-beat tick is followed at once by the shift that closes it
	`SLSP_ASSERT_NEXT(a_second_beat, rsp_valid && rsp_ready && !last, rsp_valid && shift_happened && last, "second shift beat missing")

endmodule

bind serial_link_shift_port slsp_checker u_slsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.read_data      (rsp.read_data),
	.shift_happened (rsp.shift_happened),
	.out_bit        (rsp.out_bit),
	.transfer_done  (rsp.transfer_done),
	.last           (rsp.last)
);

`default_nettype wire
